/* rtl/hdlctx_pkg.sv */
// Shared types, constants and helper functions of the HDLC async frame transmitter.
package hdlctx_pkg;

    localparam logic [7:0]  FLAG_OCTET   = 8'h7E;
    localparam logic [7:0]  ESCAPE_OCTET = 8'h7D;
    localparam logic [7:0]  ESCAPE_XOR   = 8'h20;
    localparam logic [15:0] FCS_START    = 16'hFFFF;
    localparam logic [15:0] FCS_POLY     = 16'h8408;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified word handed from front to back.
    // data: payload byte in the low half for a data word, inverted FCS for an end word.
    typedef struct packed {
        logic        open_flag;
        logic        is_end;
        logic [15:0] data;
    } t_job;

    typedef enum logic [2:0] {
        ST_OPEN,
        ST_ESC0,
        ST_DAT0,
        ST_ESC1,
        ST_DAT1,
        ST_CLOSE
    } t_step;

    // CRC-16/X-25 update by one byte, LSB first.
    function automatic logic [15:0] fcs_add_byte(logic [15:0] fcs, logic [7:0] b);
        logic [15:0] c;
        c = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic needs_escape(logic [7:0] b);
        return (b == ESCAPE_OCTET) || (b == FLAG_OCTET);
    endfunction

endpackage

/* rtl/hdlctx_front.sv */
// Front end: accepts input words, tracks frame state and the running FCS, emits jobs.
module hdlctx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [7:0]        i_payload,
    input  logic              i_queue_full,
    output logic              o_push,
    output hdlctx_pkg::t_job  o_job
);

    logic        r_frame_open;
    logic [15:0] r_fcs;
    logic        n_frame_open;
    logic [15:0] n_fcs;
    logic [15:0] fcs_base;
    logic        accept;

    assign o_ready  = !i_queue_full;
    assign accept   = i_valid && !i_queue_full;
    assign o_push   = accept;
    assign fcs_base = r_frame_open ? r_fcs : hdlctx_pkg::FCS_START;

    always_comb begin
        o_job.open_flag = !r_frame_open;
        o_job.is_end    = (i_op == hdlctx_pkg::OP_END);
        n_frame_open    = r_frame_open;
        n_fcs           = r_fcs;
        if (i_op == hdlctx_pkg::OP_END) begin
            o_job.data = ~fcs_base;
            if (accept) begin
                n_frame_open = 1'b0;
                n_fcs        = hdlctx_pkg::FCS_START;
            end
        end else begin
            o_job.data = {8'h00, i_payload};
            if (accept) begin
                n_frame_open = 1'b1;
                n_fcs        = hdlctx_pkg::fcs_add_byte(fcs_base, i_payload);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_fcs        <= hdlctx_pkg::FCS_START;
        end else begin
            r_frame_open <= n_frame_open;
            r_fcs        <= n_fcs;
        end
    end

endmodule

/* rtl/hdlctx_queue.sv */
// Short job queue between front and back ends.
module hdlctx_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hdlctx_pkg::t_job  i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output hdlctx_pkg::t_job  o_job
);

    localparam int AW = hdlctx_pkg::QUEUE_AW;

    hdlctx_pkg::t_job r_mem [hdlctx_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (AW+1)'(hdlctx_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/hdlctx_back.sv */
// Back end: expands jobs into line octets, one per cycle while the receiver is ready, into an output register.
module hdlctx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  hdlctx_pkg::t_job  i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last
);

    logic              r_busy;
    hdlctx_pkg::t_job  r_job;
    hdlctx_pkg::t_step r_step;
    hdlctx_pkg::t_step n_step;
    hdlctx_pkg::t_step first_step;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic       can_load;
    logic       emit;
    logic       step_last;
    logic [7:0] step_byte;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    logic [7:0] new_lo;

    assign lo_byte  = r_job.data[7:0];
    assign hi_byte  = r_job.data[15:8];
    assign new_lo   = i_job.data[7:0];
    assign can_load = !r_out_valid || i_ready;
    assign emit     = r_busy && can_load;
    // next job loads in the cycle the current one sends its last octet
    assign o_pop    = i_job_valid && (!r_busy || (emit && step_last));

    always_comb begin
        if (i_job.open_flag) begin
            first_step = hdlctx_pkg::ST_OPEN;
        end else if (hdlctx_pkg::needs_escape(new_lo)) begin
            first_step = hdlctx_pkg::ST_ESC0;
        end else begin
            first_step = hdlctx_pkg::ST_DAT0;
        end
    end

    // next state
    always_comb begin
        n_step = r_step;
        unique case (r_step)
            hdlctx_pkg::ST_OPEN:
                n_step = hdlctx_pkg::needs_escape(lo_byte) ? hdlctx_pkg::ST_ESC0
                                                           : hdlctx_pkg::ST_DAT0;
            hdlctx_pkg::ST_ESC0: n_step = hdlctx_pkg::ST_DAT0;
            hdlctx_pkg::ST_DAT0:
                n_step = hdlctx_pkg::needs_escape(hi_byte) ? hdlctx_pkg::ST_ESC1
                                                           : hdlctx_pkg::ST_DAT1;
            hdlctx_pkg::ST_ESC1: n_step = hdlctx_pkg::ST_DAT1;
            hdlctx_pkg::ST_DAT1: n_step = hdlctx_pkg::ST_CLOSE;
            hdlctx_pkg::ST_CLOSE: n_step = hdlctx_pkg::ST_CLOSE;
            default:             n_step = hdlctx_pkg::ST_CLOSE;
        endcase
    end

    // outputs
    always_comb begin
        step_byte = hdlctx_pkg::FLAG_OCTET;
        step_last = 1'b0;
        unique case (r_step)
            hdlctx_pkg::ST_OPEN: step_byte = hdlctx_pkg::FLAG_OCTET;
            hdlctx_pkg::ST_ESC0: step_byte = hdlctx_pkg::ESCAPE_OCTET;
            hdlctx_pkg::ST_DAT0: begin
                step_byte = hdlctx_pkg::needs_escape(lo_byte) ?
                            (lo_byte ^ hdlctx_pkg::ESCAPE_XOR) : lo_byte;
                step_last = !r_job.is_end;
            end
            hdlctx_pkg::ST_ESC1: step_byte = hdlctx_pkg::ESCAPE_OCTET;
            hdlctx_pkg::ST_DAT1: begin
                step_byte = hdlctx_pkg::needs_escape(hi_byte) ?
                            (hi_byte ^ hdlctx_pkg::ESCAPE_XOR) : hi_byte;
            end
            hdlctx_pkg::ST_CLOSE: begin
                step_byte = hdlctx_pkg::FLAG_OCTET;
                step_last = 1'b1;
            end
            default: begin
                step_byte = hdlctx_pkg::FLAG_OCTET;
                step_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (can_load) begin
            r_out_byte <= step_byte;
            r_out_last <= step_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= hdlctx_pkg::ST_OPEN;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= first_step;
            end else if (emit && step_last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_step <= n_step;
            end
            if (can_load) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

/* rtl/hdlc_async_frame_transmitter.sv */
// Top level of the HDLC async frame transmitter: front end, job queue, back end.
//
// Input stream (s): one word per payload byte (tuser = 0, tdata = byte) or an
// end-of-frame command (tuser = 1, tdata ignored). The first byte of a frame is
// preceded by an opening flag 0x7E; bytes 0x7D/0x7E are escaped as 0x7D, b^0x20;
// an end command appends the inverted CRC-16/X-25 FCS (low byte first, each
// stuffed) and a closing flag. An end with no open frame sends an empty frame.
// Output stream (m): one line octet per word; tlast marks the last octet caused
// by one input word.
// Throughput: the back end sends one octet per cycle while the receiver is ready;
// an input word expands to one octet for a plain data byte and two for an escaped
// one, plus any flag and FCS octets; the FCS update runs in the front end on accept.
// An accepted word passes the job queue and the back-end job register to the output.
// A 4-entry job queue lets the front keep accepting while the back end works.
// When the receiver stalls, the output register holds, the back end stops, the
// queue fills and tready drops. Reset empties the queue, clears the output and
// closes any open frame with the FCS back at 0xFFFF.
module hdlc_async_frame_transmitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] payload
    input  logic       i_s_tuser,   // [0] op
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] line_byte
    output logic       o_m_tlast
);

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_valid;
    hdlctx_pkg::t_job front_job;
    hdlctx_pkg::t_job back_job;

    hdlctx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_op         (i_s_tuser),
        .i_payload    (i_s_tdata),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    hdlctx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_job   (back_job)
    );

    hdlctx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (back_job),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_byte      (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule
